[rtl/lot_pkg.sv]
// lot_pkg: shared types and codes for the lock ownership tracker
// used by lot_ctrl, lot_dp and lock_ownership_tracker
`timescale 1ns / 1ps
package lot_pkg;

  typedef enum logic [1:0] {
    ACT_ENTER  = 2'd0,
    ACT_LEAVE  = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_NO_REC   = 3'd2,
    ST_INVALID  = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_REPORTED = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC,
    S_MOVE,
    S_CLEAR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        section_id;
    logic [31:0]        return_address;
    logic signed [31:0] recursion_before;
    logic signed [31:0] recursion_after;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] first_address;
    logic [31:0] last_address;
    logic [30:0] held_depth;
    logic [31:0] entries_counted;
    logic        provenance_gap;
    logic [63:0] first_sequence;
    logic [63:0] last_sequence;
    logic [63:0] dropped_total;
    logic [63:0] mismatch_total;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic rd_hit;
    logic exec;
    logic move;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need_move;
  } sts_t;

  typedef struct packed {
    logic [30:0] depth;
    logic [31:0] first_addr;
    logic [31:0] last_addr;
    logic [31:0] count;
    logic        gap;
    logic [63:0] first_seq;
    logic [63:0] last_seq;
  } rec_t;

endpackage

[rtl/lock_ownership_tracker.sv]
// lock_ownership_tracker: top level, lock ownership record table
// depends on lot_pkg, lot_ctrl, lot_dp
//
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    in_data_i  (in_t)
// out       output     out_valid_o / out_ready_i  out_data_o (out_t)
//
// one transaction at a time: the states run IDLE, SCAN, READ, EXEC, then OUT; the one-slot-per-cycle
// section scan stops at the first valid matching slot on a hit, at occupancy on a miss
// a removal adds the MOVE and CLEAR states between EXEC and OUT
// a stalled result holds in the output register; no new input until taken
// reset clears occupancy, valid bits and counters at once, no clearing pass
`timescale 1ns / 1ps
module lock_ownership_tracker
  import lot_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  lot_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lot_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );

endmodule

[rtl/lot_ctrl.sv]
// lot_ctrl: sequencing state machine for the tracker
// depends on lot_pkg
`timescale 1ns / 1ps
module lot_ctrl
  import lot_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (sts_i.scan_done) state_d = S_READ;
      S_READ:  state_d = S_EXEC;
      S_EXEC:  state_d = sts_i.need_move ? S_MOVE : S_OUT;
      S_MOVE:  state_d = S_CLEAR;
      S_CLEAR: state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o         = 1'b1;
        cmd_o.load         = in_valid_i;
        cmd_o.scan_start   = in_valid_i;
      end
      S_SCAN:  cmd_o.scan_step = 1'b1;
      S_READ:  cmd_o.rd_hit = 1'b1;
      S_EXEC:  cmd_o.exec = 1'b1;
      S_MOVE:  cmd_o.move = 1'b1;
      S_CLEAR: cmd_o.clear = 1'b1;
      S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_move_then_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.move |=> cmd_o.clear) else $error("move not followed by clear");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

endmodule

[rtl/lot_dp.sv]
// lot_dp: record table, scan, update and counters
// depends on lot_pkg
`timescale 1ns / 1ps
module lot_dp
  import lot_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output out_t out_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  logic [31:0] sec_q [TABLE_ENTRIES];
  rec_t        rec_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;

  in_t         req_q;
  logic [CW-1:0] occ_q, scan_q;
  logic        hit_q;
  logic [IW-1:0] hit_idx_q, last_idx_q;
  rec_t        rd_q, mv_q;
  logic [63:0] ev_q, drop_q, mis_q;
  out_t        res_q;

  // next values of the exec step
  rec_t          wr;
  logic [IW-1:0] wr_idx;
  logic          wr_en;
  logic          move_d;
  out_t          res_d;
  logic [CW-1:0] occ_d;
  logic [63:0]   ev_d, drop_d, mis_d;

  logic [IW-1:0] scan_idx;
  assign scan_idx = scan_q[IW-1:0];
  assign sts_o.scan_done = hit_q || (scan_q >= occ_q) ||
                           (sec_q[scan_idx] == req_q.section_id && vld_q[scan_idx]);
  assign sts_o.need_move = move_d;
  assign out_o = res_q;

  // per-transaction values
  logic [63:0] seq;
  logic        found;
  logic signed [32:0] bef, aft;
  logic [31:0] edepth;
  assign seq   = ev_q + 64'd1;
  assign found = hit_q;
  assign bef   = {req_q.recursion_before[31], req_q.recursion_before};
  assign aft   = {req_q.recursion_after[31], req_q.recursion_after};
  assign edepth = (bef > 0) ? req_q.recursion_before : 32'd1;

  rec_t rd_val;
  always_comb begin
    rd_val = vld_q[hit_idx_q] ? rec_mem[hit_idx_q] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_i;
    if (cmd_i.rd_hit) begin
      rd_q <= rd_val;
      mv_q <= vld_q[last_idx_q] ? rec_mem[last_idx_q] : '0;
    end
  end

  logic [31:0] mv_sec;
  assign mv_sec = sec_q[last_idx_q];

  always_comb begin
    wr_en  = 1'b0;
    wr     = rd_q;
    wr_idx = hit_idx_q;
    move_d = 1'b0;
    res_d  = '0;
    occ_d  = occ_q;
    ev_d   = ev_q;
    drop_d = drop_q;
    mis_d  = mis_q;
    if (req_q.action == ACT_QUERY) begin
      res_d.status = ST_OK;
      res_d.found  = found;
      if (found) begin
        res_d.first_address   = rd_q.first_addr;
        res_d.last_address    = rd_q.last_addr;
        res_d.held_depth      = rd_q.depth;
        res_d.entries_counted = rd_q.count;
        res_d.provenance_gap  = rd_q.gap;
        res_d.first_sequence  = rd_q.first_seq;
        res_d.last_sequence   = rd_q.last_seq;
      end
    end else begin
      ev_d = seq;
      res_d.last_sequence = seq;
      res_d.status = ST_OK;
      unique case (req_q.action)
        ACT_ENTER: begin
          if (!found && occ_q >= CW'(TABLE_ENTRIES)) begin
            drop_d = drop_q + 64'd1;
            res_d.status = ST_DROPPED;
          end else begin
            wr_en = 1'b1;
            if (!found) begin
              wr_idx = IW'(occ_q);
              occ_d  = occ_q + CW'(1);
            end
            if (!found || edepth == 32'd1) begin
              wr.first_addr = req_q.return_address;
              wr.count      = 32'd1;
              wr.first_seq  = seq;
              wr.gap        = (bef != 33'sd1);
            end else begin
              if (rd_q.count != 32'hFFFF_FFFF) wr.count = rd_q.count + 32'd1;
              if (bef <= 0 || edepth != {1'b0, rd_q.depth} + 32'd1) wr.gap = 1'b1;
            end
            wr.last_addr = req_q.return_address;
            wr.depth     = edepth[30:0];
            wr.last_seq  = seq;
          end
        end
        ACT_LEAVE: begin
          if (!found) begin
            mis_d = mis_q + 64'd1;
            res_d.status = ST_NO_REC;
          end else if (bef <= 0 || aft < 0 || aft >= bef) begin
            wr_en  = 1'b1;
            wr.gap = 1'b1;
            mis_d  = mis_q + 64'd1;
            res_d.status = ST_INVALID;
          end else begin
            if ({2'b00, rd_q.depth} != bef) begin
              wr.gap = 1'b1;
              mis_d  = mis_q + 64'd1;
              res_d.status = ST_MISMATCH;
            end
            if (aft == 0) begin
              move_d = 1'b1;
              occ_d  = occ_q - CW'(1);
            end else begin
              wr_en = 1'b1;
              wr.depth = req_q.recursion_after[30:0];
              wr.last_seq = seq;
            end
          end
        end
        default: begin
          mis_d = mis_q + 64'd1;
          res_d.status = ST_REPORTED;
        end
      endcase
    end
    res_d.dropped_total  = drop_d;
    res_d.mismatch_total = mis_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      occ_q  <= '0;
      scan_q <= '0;
      hit_q  <= 1'b0;
      hit_idx_q  <= '0;
      last_idx_q <= '0;
      ev_q   <= '0;
      drop_q <= '0;
      mis_q  <= '0;
      res_q  <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
      end
      if (cmd_i.scan_step && !sts_o.scan_done) scan_q <= scan_q + CW'(1);
      if (cmd_i.scan_step && sts_o.scan_done && !hit_q) begin
        hit_q     <= (scan_q < occ_q);
        hit_idx_q <= scan_idx;
        last_idx_q <= IW'(occ_q - CW'(1));
      end
      if (cmd_i.exec) begin
        occ_q  <= occ_d;
        ev_q   <= ev_d;
        drop_q <= drop_d;
        mis_q  <= mis_d;
        res_q  <= res_d;
        if (wr_en) begin
          vld_q[wr_idx] <= 1'b1;
        end
      end
      if (cmd_i.clear) vld_q[last_idx_q] <= 1'b0;
    end
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      rec_mem[wr_idx] <= wr;
      sec_q[wr_idx]   <= req_q.section_id;
    end
    if (cmd_i.move && hit_idx_q != last_idx_q) begin
      rec_mem[hit_idx_q] <= mv_q;
      sec_q[hit_idx_q]   <= mv_sec;
    end
  end

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(TABLE_ENTRIES)) else $error("occupancy overflow");
  a_move_had_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move |-> hit_q) else $error("remove without record");
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && req_q.action != ACT_QUERY |=> ev_q == $past(ev_q) + 64'd1)
    else $error("sequence did not advance");

endmodule

[test/tb_lock_ownership_tracker.sv]
// tb_lock_ownership_tracker: self-checking bench for the lock ownership tracker
// depends on lot_pkg and lock_ownership_tracker; predicts each result in a local table model
`timescale 1ns / 1ps
module tb_lock_ownership_tracker;
  import lot_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  lock_ownership_tracker #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  logic [31:0] tbl_section [TABLE_ENTRIES];
  logic [31:0] tbl_first_addr [TABLE_ENTRIES];
  logic [31:0] tbl_last_addr [TABLE_ENTRIES];
  logic [30:0] tbl_depth [TABLE_ENTRIES];
  logic [31:0] tbl_count [TABLE_ENTRIES];
  logic        tbl_gap [TABLE_ENTRIES];
  logic [63:0] tbl_first_seq [TABLE_ENTRIES];
  logic [63:0] tbl_last_seq [TABLE_ENTRIES];
  int unsigned tbl_used;
  logic [63:0] seq_count, drop_count, miss_count;

  out_t pending_results[$];
  int unsigned fail_count;
  longint unsigned cycle_count;
  bit sender_idle_ok, receiver_idle_ok;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } stim_row_t;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  function automatic int find_section(input logic [31:0] id);
    for (int i = 0; i < int'(tbl_used); i++)
      if (tbl_section[i] == id) return i;
    return -1;
  endfunction

  function automatic void wipe_slot(input int i);
    tbl_section[i] = '0; tbl_first_addr[i] = '0; tbl_last_addr[i] = '0;
    tbl_depth[i] = '0; tbl_count[i] = '0; tbl_gap[i] = 1'b0;
    tbl_first_seq[i] = '0; tbl_last_seq[i] = '0;
  endfunction

  function automatic out_t track_lock_event(input in_t t);
    out_t r;
    int i, last;
    logic [63:0] seq;
    longint prior, after;
    logic [31:0] depth;
    bit fresh;
    r = '0;
    prior = longint'(t.recursion_before);
    after = longint'(t.recursion_after);
    if (action_e'(t.action) == ACT_QUERY) begin
      i = find_section(t.section_id);
      r.status = ST_OK;
      if (i >= 0) begin
        r.found = 1'b1;
        r.first_address = tbl_first_addr[i];
        r.last_address = tbl_last_addr[i];
        r.held_depth = tbl_depth[i];
        r.entries_counted = tbl_count[i];
        r.provenance_gap = tbl_gap[i];
        r.first_sequence = tbl_first_seq[i];
        r.last_sequence = tbl_last_seq[i];
      end
    end else begin
      seq_count++;
      seq = seq_count;
      r.last_sequence = seq;
      r.status = ST_OK;
      case (action_e'(t.action))
        ACT_ENTER: begin
          depth = prior > 0 ? t.recursion_before : 32'd1;
          i = find_section(t.section_id);
          fresh = 1'b0;
          if (i < 0) begin
            if (tbl_used >= TABLE_ENTRIES) begin
              drop_count++;
              r.status = ST_DROPPED;
              i = -1;
            end else begin
              i = tbl_used;
              tbl_used++;
              fresh = 1'b1;
            end
          end else fresh = (depth == 1);
          if (i >= 0) begin
            if (fresh) begin
              tbl_section[i] = t.section_id;
              tbl_first_addr[i] = t.return_address;
              tbl_count[i] = 1;
              tbl_first_seq[i] = seq;
              tbl_gap[i] = (prior != 1);
            end else begin
              if (tbl_count[i] != '1) tbl_count[i]++;
              if (prior <= 0 || {1'b0, depth} != {2'b0, tbl_depth[i]} + 33'd1) tbl_gap[i] = 1'b1;
            end
            tbl_last_addr[i] = t.return_address;
            tbl_depth[i] = depth[30:0];
            tbl_last_seq[i] = seq;
          end
        end
        ACT_LEAVE: begin
          i = find_section(t.section_id);
          if (i < 0) begin
            miss_count++;
            r.status = ST_NO_REC;
          end else if (prior <= 0 || after < 0 || after >= prior) begin
            tbl_gap[i] = 1'b1;
            miss_count++;
            r.status = ST_INVALID;
          end else begin
            if (longint'(tbl_depth[i]) != prior) begin
              tbl_gap[i] = 1'b1;
              miss_count++;
              r.status = ST_MISMATCH;
            end
            if (after == 0) begin
              last = tbl_used - 1;
              if (i != last) begin
                tbl_section[i] = tbl_section[last]; tbl_first_addr[i] = tbl_first_addr[last];
                tbl_last_addr[i] = tbl_last_addr[last]; tbl_depth[i] = tbl_depth[last];
                tbl_count[i] = tbl_count[last]; tbl_gap[i] = tbl_gap[last];
                tbl_first_seq[i] = tbl_first_seq[last]; tbl_last_seq[i] = tbl_last_seq[last];
              end
              wipe_slot(last);
              tbl_used = last;
            end else begin
              tbl_depth[i] = t.recursion_after[30:0];
              tbl_last_seq[i] = seq;
            end
          end
        end
        default: begin
          miss_count++;
          r.status = ST_REPORTED;
        end
      endcase
    end
    r.dropped_total = drop_count;
    r.mismatch_total = miss_count;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // output side: check and random stall
  initial begin
    int hold;
    out_ready_i = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("unexpected result transaction");
          fail_count++;
        end else begin
          out_t w, g;
          w = pending_results.pop_front();
          g = out_data_o;
          if (g.status !== w.status) report("status", g.status, w.status);
          if (g.found !== w.found) report("found", g.found, w.found);
          if (g.first_address !== w.first_address)
            report("first_address", g.first_address, w.first_address);
          if (g.last_address !== w.last_address)
            report("last_address", g.last_address, w.last_address);
          if (g.held_depth !== w.held_depth) report("held_depth", g.held_depth, w.held_depth);
          if (g.entries_counted !== w.entries_counted)
            report("entries_counted", g.entries_counted, w.entries_counted);
          if (g.provenance_gap !== w.provenance_gap)
            report("provenance_gap", g.provenance_gap, w.provenance_gap);
          if (g.first_sequence !== w.first_sequence)
            report("first_sequence", g.first_sequence, w.first_sequence);
          if (g.last_sequence !== w.last_sequence)
            report("last_sequence", g.last_sequence, w.last_sequence);
          if (g.dropped_total !== w.dropped_total)
            report("dropped_total", g.dropped_total, w.dropped_total);
          if (g.mismatch_total !== w.mismatch_total)
            report("mismatch_total", g.mismatch_total, w.mismatch_total);
        end
      end
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (receiver_idle_ok && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 4) - 1;
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
    end
  end

  initial begin
    @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // called at a falling edge; valid stays up into the next call unless idling
  task automatic send_item(input in_t t);
    if (sender_idle_ok && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    pending_results.push_back(track_lock_event(t));
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic in_t make_item(input action_e a, input logic [31:0] id,
                                    input logic [31:0] addr, input logic [31:0] b,
                                    input logic [31:0] af);
    in_t t;
    t.action = a; t.section_id = id; t.return_address = addr;
    t.recursion_before = b; t.recursion_after = af;
    return t;
  endfunction

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return '1;
      2: return '0;
      default: return 32'h100 + $urandom_range(0, 19);
    endcase
  endfunction

  function automatic logic [31:0] pick_depth(input logic [31:0] near);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 3);
      default: return near;
    endcase
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    in_t t;
    out_t w;
    int i, k, drain;
    logic [31:0] id, d;
    tbl_used = 0; seq_count = '0; drop_count = '0; miss_count = '0;
    for (i = 0; i < TABLE_ENTRIES; i++) wipe_slot(i);
    fail_count = 0; cycle_count = 0;
    sender_idle_ok = 1'b1; receiver_idle_ok = 1'b1;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows
    w = '0;
    row.item = make_item(ACT_QUERY, 32'h0, 32'h0, 32'h0, 32'h0); row.typed = 1; row.want = w;
    rows.push_back(row);
    w = '0; w.status = ST_NO_REC; w.last_sequence = 1; w.mismatch_total = 1;
    row.item = make_item(ACT_LEAVE, '1, '1, 32'd1, 32'd0); row.typed = 1; row.want = w;
    rows.push_back(row);
    w = '0; w.status = ST_REPORTED; w.last_sequence = 2; w.mismatch_total = 2;
    row.item = make_item(ACT_REPORT, '1, '1, '1, '1); row.typed = 1; row.want = w;
    rows.push_back(row);
    row.typed = 0;
    row.item = make_item(ACT_ENTER, '1, '1, 32'd1, 32'd0); rows.push_back(row);
    row.item = make_item(ACT_ENTER, '1, 32'h1234, 32'd2, '1); rows.push_back(row);
    row.item = make_item(ACT_ENTER, '1, 32'h5678, 32'd5, 32'd0); rows.push_back(row);
    row.item = make_item(ACT_QUERY, '1, 32'h0, 32'h0, 32'h0); rows.push_back(row);
    row.item = make_item(ACT_LEAVE, '1, 32'h0, 32'd5, 32'd5); rows.push_back(row);
    row.item = make_item(ACT_LEAVE, '1, 32'h0, 32'h8000_0000, 32'd0); rows.push_back(row);
    row.item = make_item(ACT_LEAVE, '1, 32'h0, 32'd5, 32'hFFFF_FFFF); rows.push_back(row);
    row.item = make_item(ACT_LEAVE, '1, 32'h0, 32'd6, 32'd4); rows.push_back(row);
    row.item = make_item(ACT_LEAVE, '1, 32'h0, 32'd4, 32'd3); rows.push_back(row);
    row.item = make_item(ACT_ENTER, 32'h0, 32'h0, 32'h8000_0000, 32'd0); rows.push_back(row);
    row.item = make_item(ACT_ENTER, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'd0); rows.push_back(row);
    row.item = make_item(ACT_ENTER, 32'h0, 32'h0, 32'h0, 32'd0); rows.push_back(row);
    row.item = make_item(ACT_QUERY, 32'h0, 32'h0, 32'h0, 32'h0); rows.push_back(row);
    row.item = make_item(ACT_LEAVE, '1, 32'h0, 32'd3, 32'd0); rows.push_back(row);
    row.item = make_item(ACT_QUERY, 32'h0, 32'h0, 32'h0, 32'h0); rows.push_back(row);
    row.item = make_item(ACT_LEAVE, 32'h0, 32'h0, 32'd1, 32'd0); rows.push_back(row);
    row.item = make_item(ACT_QUERY, 32'h0, '1, '1, '1); rows.push_back(row);

    foreach (rows[j]) begin
      send_item(rows[j].item);
      if (rows[j].typed && pending_results[$] !== rows[j].want)
        report("directed row", j, 0);
    end

    // fill past capacity, then drain the table
    for (k = 0; k < TABLE_ENTRIES + 3; k++)
      send_item(make_item(ACT_ENTER, 32'h200 + k, $urandom(), 32'd1, 32'd0));
    send_item(make_item(ACT_QUERY, 32'h200 + TABLE_ENTRIES - 1, 0, 0, 0));
    for (k = 0; k < TABLE_ENTRIES; k++)
      send_item(make_item(ACT_LEAVE, 32'h200 + k, 0, 32'd1, 32'd0));

    // hold off until every result has come
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - 200) begin
        sender_idle_ok = 1'b0; receiver_idle_ok = 1'b0;
      end
      id = pick_id();
      i = find_section(id);
      d = (i >= 0) ? {1'b0, tbl_depth[i]} : 32'd0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6:
          t = make_item(ACT_ENTER, id, $urandom(), pick_depth(d + 1), $urandom());
        7, 8, 9, 10, 11, 12:
          t = make_item(ACT_LEAVE, id, $urandom(), pick_depth(d),
                        $urandom_range(0, 1) ? pick_depth(d - 1) : 32'd0);
        13:
          t = make_item(ACT_REPORT, id, $urandom(), $urandom(), $urandom());
        default:
          t = make_item(ACT_QUERY, id, $urandom(), $urandom(), $urandom());
      endcase
      send_item(t);
    end
    in_valid_i <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < 10000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
